// File: rtl/lgc_pkg.sv
// Shared constants, types and the Life rule for the column-stream generation block.
package lgc_pkg;

  localparam int HEIGHT     = 48;               // rows per column
  localparam int COL_W      = 48;               // payload width of a column
  localparam int FIFO_DEPTH = 4;                // result queue entries
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [3:0] NBR_BIRTH = 4'd3;      // live neighbors that give birth
  localparam logic [3:0] NBR_STAY  = 4'd2;      // extra count that keeps a live cell

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic accept;   // input transaction this cycle
    logic keep;     // a pending column survives (no frame restart)
    logic last;     // column closes the frame
  } cell_ctrl_t;

  typedef struct packed {
    logic [COL_W-1:0] next_cells;
    logic             last_column;
  } result_t;

  // Queue status seen by the stream control
  typedef struct packed {
    logic room2;    // at least two free entries
    logic busy;     // at least one entry held
  } fifo_stat_t;

  function automatic logic [3:0] nbr_count(input logic [7:0] nbr);
    logic [3:0] sum;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, nbr[i]};
    end
    return sum;
  endfunction

  function automatic logic life_rule(input logic alive, input logic [3:0] n);
    return (n == NBR_BIRTH) || (alive && (n == NBR_STAY));
  endfunction

endpackage

// File: rtl/lgc_if.sv
// Valid/ready channel interfaces for column transactions in and result transactions out.
interface lgc_in_if;
  logic                      valid;
  logic                      ready;
  logic [lgc_pkg::COL_W-1:0] column_cells;
  logic                      frame_start;
  logic                      frame_end;

  modport source (output valid, output column_cells, output frame_start,
                  output frame_end, input ready);
  modport sink   (input valid, input column_cells, input frame_start,
                  input frame_end, output ready);
endinterface

interface lgc_out_if;
  logic                      valid;
  logic                      ready;
  logic [lgc_pkg::COL_W-1:0] next_cells;
  logic                      last_column;

  modport source (output valid, output next_cells, output last_column, input ready);
  modport sink   (input valid, input next_cells, input last_column, output ready);
endinterface

// File: rtl/lgc_cell.sv
// One row cell: holds left/middle bits of its row and evaluates the Life rule.
module lgc_cell (
  input  logic                clk,
  input  lgc_pkg::cell_ctrl_t ctrl,
  input  logic                col_dn,
  input  logic                col_c,
  input  logic                col_up,
  input  logic                left_dn,
  input  logic                left_up,
  input  logic                mid_dn,
  input  logic                mid_up,
  output logic                left_o,
  output logic                mid_o,
  output logic                res_norm,
  output logic                res_flush
);

  logic left_r, left_nxt;
  logic mid_r,  mid_nxt;
  logic nl_dn, nl_c, nl_up;   // left column once the new column shifts in

  assign left_o = left_r;
  assign mid_o  = mid_r;

  assign nl_dn = ctrl.keep & mid_dn;
  assign nl_c  = ctrl.keep & mid_r;
  assign nl_up = ctrl.keep & mid_up;

  // pending column closed by the incoming one
  assign res_norm = lgc_pkg::life_rule(mid_r, lgc_pkg::nbr_count(
      {left_dn, mid_dn, col_dn, left_r, col_c, left_up, mid_up, col_up}));

  // incoming column closed by a dead column on its right
  assign res_flush = lgc_pkg::life_rule(col_c, lgc_pkg::nbr_count(
      {nl_dn, col_dn, 1'b0, nl_c, 1'b0, nl_up, col_up, 1'b0}));

  always_comb begin
    left_nxt = left_r;
    mid_nxt  = mid_r;
    if (ctrl.accept) begin
      if (ctrl.last) begin
        left_nxt = 1'b0;
        mid_nxt  = 1'b0;
      end else begin
        left_nxt = nl_c;
        mid_nxt  = col_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    mid_r  <= mid_nxt;
  end

endmodule

// File: rtl/lgc_out_fifo.sv
// Small result queue taking up to two results per cycle and giving one.
module lgc_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push0,
  input  logic                push1,
  input  lgc_pkg::result_t    din0,
  input  lgc_pkg::result_t    din1,
  input  logic                pop,
  output lgc_pkg::result_t    dout,
  output lgc_pkg::fifo_stat_t stat
);

  lgc_pkg::result_t         mem_r [lgc_pkg::FIFO_DEPTH];
  logic [lgc_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lgc_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lgc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [lgc_pkg::PTR_W-1:0] wr_ptr_p1;
  logic [lgc_pkg::CNT_W-1:0] n_push;

  assign wr_ptr_p1  = wr_ptr_r + lgc_pkg::PTR_W'(1);
  assign n_push     = lgc_pkg::CNT_W'(push0) + lgc_pkg::CNT_W'(push1);
  assign wr_ptr_nxt = wr_ptr_r + n_push[lgc_pkg::PTR_W-1:0];
  assign rd_ptr_nxt = rd_ptr_r + lgc_pkg::PTR_W'(pop);
  assign count_nxt  = count_r + n_push - lgc_pkg::CNT_W'(pop);

  assign dout       = mem_r[rd_ptr_r];
  assign stat.busy  = (count_r != '0);
  assign stat.room2 = (count_r <= lgc_pkg::CNT_W'(lgc_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_ptr_r] <= din0;
    end
    if (push1) begin
      mem_r[wr_ptr_p1] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/life_generation_column_stream.sv
// Top level: Conway Life (B3/S23) generation over a left-to-right column stream.
//
//  channel   dir  handshake     payload
//  in_col    in   valid/ready   column_cells[47:0], frame_start, frame_end
//  out_col   out  valid/ready   next_cells[47:0], last_column
//
// One column transaction is taken per cycle when ready; its results are computed in the
// same cycle by a row of HEIGHT cells and written into a 4-entry result queue.
// A column yields zero, one or two results (two when it closes a frame with a
// column already pending). in_col.ready is high while the queue has at least two free
// entries, so it depends on registered state only; out_col stalls fill the
// queue and then stop input. Synchronous active-low reset clears the queue and
// the pending flag; cell bits need no reset since they are ignored until written.
module life_generation_column_stream (
  input  logic        clk,
  input  logic        rst_n,
  lgc_in_if.sink      in_col,
  lgc_out_if.source   out_col
);

  localparam int H = lgc_pkg::HEIGHT;

  // Pending-column flag: a middle column waits for its right neighbor.
  logic mid_valid_r, mid_valid_nxt;

  lgc_pkg::cell_ctrl_t ctrl;
  lgc_pkg::fifo_stat_t fstat;
  lgc_pkg::result_t    res0, res1, head;

  logic         accept;
  logic [H-1:0] col_h;
  logic [H-1:0] left_v, mid_v;
  logic [H-1:0] norm_v, flush_v;
  logic [H+1:0] col_pad, left_pad, mid_pad;   // dead rows at both ends
  logic [lgc_pkg::COL_W-1:0] norm_w, flush_w;
  logic         push0, push1;

  assign in_col.ready = fstat.room2;
  assign accept       = in_col.valid & in_col.ready;

  // A frame start drops whatever was pending.
  assign ctrl.accept = accept;
  assign ctrl.keep   = mid_valid_r & ~in_col.frame_start;
  assign ctrl.last   = in_col.frame_end;

  // Rows at or above HEIGHT are dead.
  always_comb begin
    col_h = '0;
    for (int y = 0; y < H; y++) begin
      if (y < lgc_pkg::COL_W) begin
        col_h[y] = in_col.column_cells[y];
      end
    end
  end

  assign col_pad  = {1'b0, col_h, 1'b0};
  assign left_pad = {1'b0, left_v, 1'b0};
  assign mid_pad  = {1'b0, mid_v, 1'b0};

  // Cell y sees stored rows y-1 and y+1 through its neighbors' registers.
  for (genvar y = 0; y < H; y++) begin : g_row
    lgc_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .col_dn    (col_pad[y]),
      .col_c     (col_pad[y+1]),
      .col_up    (col_pad[y+2]),
      .left_dn   (left_pad[y]),
      .left_up   (left_pad[y+2]),
      .mid_dn    (mid_pad[y]),
      .mid_up    (mid_pad[y+2]),
      .left_o    (left_v[y]),
      .mid_o     (mid_v[y]),
      .res_norm  (norm_v[y]),
      .res_flush (flush_v[y])
    );
  end

  always_comb begin
    norm_w  = '0;
    flush_w = '0;
    for (int y = 0; y < lgc_pkg::COL_W; y++) begin
      if (y < H) begin
        norm_w[y]  = norm_v[y];
        flush_w[y] = flush_v[y];
      end
    end
  end

  // First result: the pending column if any, else the one-column frame flush.
  assign res0.next_cells  = ctrl.keep ? norm_w : flush_w;
  assign res0.last_column = ~ctrl.keep;
  assign res1.next_cells  = flush_w;
  assign res1.last_column = 1'b1;

  assign push0 = accept & (ctrl.keep | ctrl.last);
  assign push1 = accept & ctrl.keep & ctrl.last;

  lgc_out_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push0 (push0),
    .push1 (push1),
    .din0  (res0),
    .din1  (res1),
    .pop   (out_col.valid & out_col.ready),
    .dout  (head),
    .stat  (fstat)
  );

  assign out_col.valid       = fstat.busy;
  assign out_col.next_cells  = head.next_cells;
  assign out_col.last_column = head.last_column;

  assign mid_valid_nxt = accept ? ~in_col.frame_end : mid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else begin
      mid_valid_r <= mid_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_col.frame_end) |=> out_col.valid)
    else $error("frame end transaction left no result");

  a_pending_after_col: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_col.frame_end) |=> mid_valid_r)
    else $error("column not held pending");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_col.frame_end) |=> !mid_valid_r)
    else $error("pending column survived frame end");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_col.valid && !out_col.ready && !in_col.ready) |=> out_col.valid)
    else $error("stalled queue lost its head");
`endif

endmodule
